/* rtl/rj_pkg.sv */
// ----------------------------------------------------------------------------
// rj_pkg
// Types, constants and helpers shared by the radar Jacobian pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rj_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } t_rj_in;

    typedef struct packed {
        logic signed [31:0] range_by_x;
        logic signed [31:0] range_by_y;
        logic signed [31:0] bearing_by_x;
        logic signed [31:0] bearing_by_y;
        logic signed [31:0] rate_by_x;
        logic signed [31:0] rate_by_y;
        logic               too_close;
    } t_rj_out;

    localparam logic [15:0] RJ_MIN_R2_RST = 16'd7;
    // cycles from an accepted start to its o_done strobe
    localparam int RJ_LAT = 54;

    // sign and saturate a magnitude into signed Q16.16
    function automatic logic [31:0] rj_sat(input logic neg, input logic [64:0] mag);
        logic [31:0] res;
        if (neg) begin
            if (mag > 65'd2147483648) res = 32'h8000_0000;
            else                      res = ~mag[31:0] + 32'd1;
        end else begin
            if (mag > 65'd2147483647) res = 32'h7FFF_FFFF;
            else                      res = mag[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/radar_jacobian.sv */
// ----------------------------------------------------------------------------
// radar_jacobian
// Radar measurement Jacobian of a 2D constant-velocity state, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a state beat on i_data; busy stays low, so a beat is
//   taken on every cycle start is high. One result beat per input.
//   Each result appears on o_result for one cycle with o_done high, in input
//   order; o_done is the accepted start carried down the r_vld shift register.
//   Throughput: one beat per cycle. Results pass through the square root
//   pipeline (32 stages) followed by the 17-stage range divider, plus input,
//   product, sum, multiply and output stages.
//   i_cfg_we/i_cfg_wdata load the range-squared threshold; write it only
//   while no beat is in flight.
//   Reset (synchronous, active low) clears every in-flight beat and sets
//   the threshold to 7. The receiver cannot stall; o_done is a strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module radar_jacobian
    import rj_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_rj_in      i_data,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_done,
    output t_rj_out          o_result
);

    logic [15:0]     r_min_r2;
    logic [RJ_LAT-1:0] r_vld;

    // stage 1: magnitudes
    logic [31:0]        r_ax1, r_ay1;
    logic               r_xn1, r_yn1;
    logic signed [31:0] r_x1, r_y1, r_vx1, r_vy1;
    // stage 2: products
    logic [63:0]        r_pxx, r_pyy;
    logic signed [63:0] r_pvxy, r_pvyx;
    logic [31:0]        r_ax2, r_ay2;
    logic               r_xn2, r_yn2;
    // stage 3: r^2 and cross term
    logic [63:0]        r_s, r_dmag;
    logic [31:0]        r_ax3, r_ay3;
    logic               r_xn3, r_yn3, r_dn3;
    logic [64:0]        n_d;
    // stage 4: flags
    logic               r_close4, r_clamp4;

    logic [31:0] root;
    logic [63:0] axy_d;
    logic [16:0] rx_q, ry_q;
    logic [32:0] bx_q, by_q;
    logic [47:0] b_q;
    logic        clamp_d;
    logic [47:0] r_bmag;
    logic [16:0] r_rx, r_ry;
    logic [40:0] r_px0, r_px1, r_py0, r_py1;
    logic [65:0] bxy_d;
    logic [2:0]  sgn_d;
    logic        close_d;
    logic [64:0] px_sum, py_sum;
    t_rj_out     n_res, r_res;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_r2 <= RJ_MIN_R2_RST;
            r_vld    <= '0;
        end else begin
            if (i_cfg_we) r_min_r2 <= i_cfg_wdata;
            r_vld <= {r_vld[RJ_LAT-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_xn1 <= i_data.pos_x[31];
        r_yn1 <= i_data.pos_y[31];
        r_ax1 <= i_data.pos_x[31] ? ~i_data.pos_x + 32'd1 : i_data.pos_x;
        r_ay1 <= i_data.pos_y[31] ? ~i_data.pos_y + 32'd1 : i_data.pos_y;
        r_x1  <= i_data.pos_x;
        r_y1  <= i_data.pos_y;
        r_vx1 <= i_data.vel_x;
        r_vy1 <= i_data.vel_y;

        r_pxx  <= r_ax1 * r_ax1;
        r_pyy  <= r_ay1 * r_ay1;
        r_pvxy <= r_vx1 * r_y1;
        r_pvyx <= r_vy1 * r_x1;
        r_ax2  <= r_ax1;
        r_ay2  <= r_ay1;
        r_xn2  <= r_xn1;
        r_yn2  <= r_yn1;

        r_s    <= r_pxx + r_pyy;
        r_dn3  <= n_d[64];
        r_dmag <= n_d[64] ? 64'(~n_d + 65'd1) : n_d[63:0];
        r_ax3  <= r_ax2;
        r_ay3  <= r_ay2;
        r_xn3  <= r_xn2;
        r_yn3  <= r_yn2;

        r_close4 <= (r_s == 64'd0) || (r_s < {32'd0, r_min_r2, 16'd0});
        // quotient of the cross-term divide would reach 2^47
        r_clamp4 <= {31'd0, r_dmag} >= {r_s, 31'd0};
    end

    assign n_d = {r_pvxy[63], r_pvxy} - {r_pvyx[63], r_pvyx};

    rj_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_s    (r_s),
        .o_root (root)
    );

    rj_delay #(.W(64), .N(32)) u_dly_axy (
        .i_clk (i_clk),
        .i_d   ({r_ax3, r_ay3}),
        .o_d   (axy_d)
    );

    rj_div #(.NW(48), .DW(32), .QW(17)) u_div_rx (
        .i_clk (i_clk),
        .i_num ({axy_d[63:32], 16'd0}),
        .i_den (root),
        .o_quo (rx_q)
    );

    rj_div #(.NW(48), .DW(32), .QW(17)) u_div_ry (
        .i_clk (i_clk),
        .i_num ({axy_d[31:0], 16'd0}),
        .i_den (root),
        .o_quo (ry_q)
    );

    rj_div #(.NW(64), .DW(64), .QW(33)) u_div_bx (
        .i_clk (i_clk),
        .i_num ({r_ay3, 32'd0}),
        .i_den (r_s),
        .o_quo (bx_q)
    );

    rj_div #(.NW(64), .DW(64), .QW(33)) u_div_by (
        .i_clk (i_clk),
        .i_num ({r_ax3, 32'd0}),
        .i_den (r_s),
        .o_quo (by_q)
    );

    rj_div #(.NW(80), .DW(64), .QW(48)) u_div_b (
        .i_clk (i_clk),
        .i_num ({r_dmag, 16'd0}),
        .i_den (r_s),
        .o_quo (b_q)
    );

    rj_delay #(.W(1), .N(47)) u_dly_clamp (
        .i_clk (i_clk),
        .i_d   (r_clamp4),
        .o_d   (clamp_d)
    );

    rj_delay #(.W(66), .N(17)) u_dly_bxy (
        .i_clk (i_clk),
        .i_d   ({bx_q, by_q}),
        .o_d   (bxy_d)
    );

    rj_delay #(.W(3), .N(50)) u_dly_sgn (
        .i_clk (i_clk),
        .i_d   ({r_xn3, r_yn3, r_dn3}),
        .o_d   (sgn_d)
    );

    rj_delay #(.W(1), .N(49)) u_dly_close (
        .i_clk (i_clk),
        .i_d   (r_close4),
        .o_d   (close_d)
    );

    always_ff @(posedge i_clk) begin
        r_bmag <= clamp_d ? 48'h8000_0000_0000 : b_q;
        r_rx   <= rx_q;
        r_ry   <= ry_q;
        // split 17x48 product into two 17x24 halves
        r_px0  <= ry_q * r_bmag[23:0];
        r_px1  <= ry_q * r_bmag[47:24];
        r_py0  <= rx_q * r_bmag[23:0];
        r_py1  <= rx_q * r_bmag[47:24];
        r_res  <= n_res;
    end

    assign px_sum = 65'(r_px0) + {r_px1, 24'd0};
    assign py_sum = 65'(r_py0) + {r_py1, 24'd0};

    always_comb begin
        n_res = '0;
        if (close_d) begin
            n_res.too_close = 1'b1;
        end else begin
            n_res.range_by_x   = rj_sat(sgn_d[2], 65'(r_rx));
            n_res.range_by_y   = rj_sat(sgn_d[1], 65'(r_ry));
            n_res.bearing_by_x = rj_sat(~sgn_d[1], 65'(bxy_d[65:33]));
            n_res.bearing_by_y = rj_sat(sgn_d[2], 65'(bxy_d[32:0]));
            n_res.rate_by_x    = rj_sat(sgn_d[1] ^ sgn_d[0], 65'(px_sum[64:16]));
            n_res.rate_by_y    = rj_sat(~(sgn_d[2] ^ sgn_d[0]), 65'(py_sum[64:16]));
        end
    end

    assign o_done   = r_vld[RJ_LAT-1];
    assign o_result = r_res;

`ifndef NO_ASSERTIONS
    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, RJ_LAT))
        else $error("result strobe without matching start");

    a_close_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.too_close) |->
            (o_result.range_by_x == 0 && o_result.range_by_y == 0 &&
             o_result.bearing_by_x == 0 && o_result.bearing_by_y == 0 &&
             o_result.rate_by_x == 0 && o_result.rate_by_y == 0))
        else $error("too_close result with nonzero terms");

    a_range_unit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.too_close) |->
            (o_result.range_by_x <= 32'sd65536 && o_result.range_by_x >= -32'sd65536 &&
             o_result.range_by_y <= 32'sd65536 && o_result.range_by_y >= -32'sd65536))
        else $error("range row exceeds unit magnitude");
`endif

endmodule

`default_nettype wire

/* rtl/rj_delay.sv */
// ----------------------------------------------------------------------------
// rj_delay
// Fixed-length shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rj_delay
    import rj_pkg::*;
#(
    parameter int W = 1,
    parameter int N = 1
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_d
);

    logic [W-1:0] r_sr [N];

    for (genvar j = 0; j < N; j++) begin : g_tap
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_sr[j] <= i_d;
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                r_sr[j] <= r_sr[j-1];
            end
        end
    end

    assign o_d = r_sr[N-1];

endmodule

`default_nettype wire

/* rtl/rj_sqrt.sv */
// ----------------------------------------------------------------------------
// rj_sqrt
// Pipelined integer square root, floor(sqrt(s)), one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rj_sqrt
    import rj_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [63:0] i_s,
    output logic      [31:0] o_root
);

    localparam int N = 32;

    logic [63:0] r_s    [N];
    logic [33:0] r_rem  [N];
    logic [31:0] r_root [N];

    for (genvar j = 0; j < N; j++) begin : g_stg
        logic [63:0] s_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [35:0] trial;
        logic [35:0] tst;
        logic [35:0] diff;
        logic        ge;

        if (j == 0) begin : g_first
            assign s_in    = i_s;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_rest
            assign s_in    = r_s[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        assign trial = {rem_in, s_in[63:62]};
        assign tst   = {2'b00, root_in, 2'b01};
        assign ge    = trial >= tst;
        assign diff  = trial - tst;

        always_ff @(posedge i_clk) begin
            r_s[j]    <= {s_in[61:0], 2'b00};
            r_rem[j]  <= ge ? diff[33:0] : trial[33:0];
            r_root[j] <= {root_in[30:0], ge};
        end
    end

    assign o_root = r_root[N-1];

endmodule

`default_nettype wire

/* rtl/rj_div.sv */
// ----------------------------------------------------------------------------
// rj_div
// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees num < den * 2^QW, so QW quotient bits suffice.
// ----------------------------------------------------------------------------
`default_nettype none

module rj_div
    import rj_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QW = 17
) (
    input  wire logic          i_clk,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_den [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stg
        logic [DW-1:0] rem_in;
        logic [QW-1:0] lo_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (j == 0) begin : g_first
            assign rem_in = DW'(i_num[NW-1:QW]);
            assign lo_in  = i_num[QW-1:0];
            assign q_in   = '0;
            assign den_in = i_den;
        end else begin : g_rest
            assign rem_in = r_rem[j-1];
            assign lo_in  = r_lo[j-1];
            assign q_in   = r_q[j-1];
            assign den_in = r_den[j-1];
        end

        assign trial = {rem_in, lo_in[QW-1]};
        assign ge    = trial >= {1'b0, den_in};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            r_rem[j] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_lo[j]  <= {lo_in[QW-2:0], 1'b0};
            r_q[j]   <= {q_in[QW-2:0], ge};
            r_den[j] <= den_in;
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

`default_nettype wire

/* bench/radar_jacobian_test.sv */
// ----------------------------------------------------------------------------
// radar_jacobian_test
// Self-checking bench for the radar Jacobian pipeline: state beats are
// driven in random bursts, each result is predicted in 64/128-bit integer
// arithmetic and compared as a whole struct, and the threshold is swept
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module radar_jacobian_test;
    import rj_pkg::*;

    localparam logic [63:0] MAG_CAP = 64'd1 << 47;
    localparam int          CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_rj_in      i_data = '0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_done;
    t_rj_out     o_result;

    radar_jacobian uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_data(i_data), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done), .o_result(o_result)
    );

    always #1 i_clk = ~i_clk;

    t_rj_in      state_queue[$];
    t_rj_out     jacobian_queue[$];
    logic [15:0] min_r2 = RJ_MIN_R2_RST;
    int          errors = 0;
    int          results_seen = 0;
    int          flagged_seen = 0;
    int          cycles = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    bit          hold_sender = 1'b0;
    logic        busy_q;

    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // floor(n * 2^k / d), clamped at 2^47
    function automatic logic [63:0] scaled_quot(input logic [63:0] n, input logic [63:0] d,
                                                input int k);
        logic [127:0] q;
        q = ({64'd0, n} << k) / {64'd0, d};
        return (q >= {64'd0, MAG_CAP}) ? MAG_CAP : q[63:0];
    endfunction

    function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
        if (neg) return (mag > 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic t_rj_out jacobian_of(input t_rj_in s, input logic [15:0] thr);
        t_rj_out o;
        logic signed [63:0] x, y, vx, vy, d;
        logic [63:0] ax, ay, r2, r, rx, ry, dmag, bmag, px, py;
        logic xneg, yneg, dneg;
        o = '0;
        x = s.pos_x; y = s.pos_y; vx = s.vel_x; vy = s.vel_y;
        xneg = x < 0; yneg = y < 0;
        ax = xneg ? -x : x;
        ay = yneg ? -y : y;
        r2 = ax * ax + ay * ay;
        if (r2 == 0 || r2 < ({48'd0, thr} << 16)) begin
            o.too_close = 1'b1;
            return o;
        end
        r = isqrt(r2);
        rx = scaled_quot(ax, r, 16);
        ry = scaled_quot(ay, r, 16);
        o.range_by_x = sat32(xneg && rx != 0, rx);
        o.range_by_y = sat32(yneg && ry != 0, ry);
        o.bearing_by_x = sat32(!yneg, scaled_quot(ay, r2, 32));
        o.bearing_by_y = sat32(xneg, scaled_quot(ax, r2, 32));
        d = vx * y - vy * x;
        dneg = d[63];
        dmag = dneg ? -d : d;
        bmag = scaled_quot(dmag, r2, 16);
        px = (ry * bmag) >> 16;
        py = (rx * bmag) >> 16;
        o.rate_by_x = sat32((yneg != dneg) && px != 0, px);
        o.rate_by_y = sat32((xneg == dneg) && py != 0, py);
        return o;
    endfunction

    // driver: bursts and gaps, changes on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && start && !busy_q) begin
            // beat accepted at the last rising edge
            jacobian_queue.push_back(jacobian_of(state_queue.pop_front(), min_r2));
        end
        if (!i_rst_n || hold_sender || state_queue.size() == 0) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            burst_left--;
            start <= 1'b1;
            i_data <= state_queue[0];
        end
    end

    always @(posedge i_clk) busy_q <= busy;

    // monitor
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("radar_jacobian regression: fail");
            $finish;
        end
        if (i_rst_n && o_done) begin
            results_seen++;
            if (o_result.too_close) flagged_seen++;
            if (jacobian_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, o_result);
            end else if (o_result !== jacobian_queue[0]) begin
                errors++;
                $display("%0t: expected %h actual %h", $time, jacobian_queue[0], o_result);
                void'(jacobian_queue.pop_front());
            end else begin
                void'(jacobian_queue.pop_front());
            end
        end
    end

    function automatic logic [31:0] rand_q(input int mode);
        logic [31:0] v;
        case (mode)
            0: v = $urandom();
            1: v = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            2: v = $signed($urandom_range(0, 2048)) - 1024;
            3: v = ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: v = $urandom() >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    task automatic push_state(input logic [31:0] x, y, vx, vy);
        t_rj_in s;
        s.pos_x = x; s.pos_y = y; s.vel_x = vx; s.vel_y = vy;
        state_queue.push_back(s);
    endtask

    // waits until every expected result is back, then holds the sender idle
    task automatic drain_pipe();
        wait (state_queue.size() == 0 && jacobian_queue.size() == 0);
        hold_sender = 1'b1;
        repeat (RJ_LAT + 4) @(posedge i_clk);
    endtask

    task automatic load_threshold(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        min_r2 = v;
    endtask

    task automatic random_phase(input int count);
        int m;
        repeat (count) begin
            m = $urandom_range(0, 4);
            push_state(rand_q(m), rand_q($urandom_range(0, 4)),
                       rand_q($urandom_range(0, 4)), rand_q($urandom_range(0, 4)));
        end
        hold_sender = 1'b0;
        drain_pipe();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: zero position, threshold edge, extremes
        push_state(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        push_state(32'd1, 0, 0, 0);
        push_state(32'd0, 32'h0000_0294, 32'h0001_0000, 0);
        push_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        push_state(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        push_state(32'h0001_0000, 0, 0, 32'h0001_0000);
        push_state(0, 32'hFFFF_0000, 32'hFFFF_0000, 0);
        push_state(32'h0003_0000, 32'h0004_0000, 32'hFFFE_0000, 32'h0005_0000);
        push_state(32'd1, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        push_state(32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h8000_0000);
        push_state(32'h0000_0100, 32'hFFFF_FF00, 32'h1234_5678, 32'h8765_4321);
        hold_sender = 1'b0;
        drain_pipe();
        load_threshold(16'd0);
        push_state(0, 0, 0, 0);
        push_state(32'd1, 0, 0, 32'h7FFF_FFFF);
        push_state(0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        random_phase(350);
        load_threshold(16'hFFFF);
        push_state(32'h00FF_FF00, 0, 0, 0);
        push_state(32'h0100_0000, 0, 0, 0);
        random_phase(350);
        load_threshold(16'd1000);
        random_phase(350);
        load_threshold(16'($urandom_range(0, 16'hFFFF)));
        random_phase(300);
        load_threshold(RJ_MIN_R2_RST);
        random_phase(350);
        $display("%0d results checked, %0d flagged too close, over 5 threshold settings",
                 results_seen, flagged_seen);
        if (errors == 0) begin
            $display("radar_jacobian regression: pass");
        end else begin
            $display("radar_jacobian regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/rj_pkg.sv
rtl/rj_delay.sv
rtl/rj_sqrt.sv
rtl/rj_div.sv
rtl/radar_jacobian.sv
bench/radar_jacobian_test.sv
